### rtl/command_line_keyword_matcher_defines.svh
// Assertion macros for the keyword matcher RTL
`ifndef COMMAND_LINE_KEYWORD_MATCHER_DEFINES_SVH
`define COMMAND_LINE_KEYWORD_MATCHER_DEFINES_SVH

`define CLKM_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");

`define CLKM_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");

`define CLKM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check violated");

`endif

### rtl/clkm_pkg.sv
// Types, constants and name table of the command line keyword matcher
`timescale 1ns / 1ps
package clkm_pkg;

   localparam int NAME_ROWS      = 34;
   localparam int ROW_W          = 6;
   localparam int NAME_MAX_CHARS = 16;
   localparam int NAME_IDX_W     = 4;
   localparam int NAME_LEN_W     = 5;
   localparam int RSP_W          = 32;

   localparam logic [7:0] CHAR_DEL    = 8'h08;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_COLON  = 8'h3A;
   localparam logic [7:0] CASE_OFFSET = 8'd32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CHECK,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      STATUS_OVERFLOW  = 2'd0,
      STATUS_HEX       = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FOUND     = 2'd3
   } status_type;

   typedef struct packed {
      logic                  clear;
      logic                  step;
      logic                  in_name;
      logic [NAME_IDX_W-1:0] pos;
      logic [7:0]            upper;
   } match_ctl_type;

   typedef struct packed {
      logic             found;
      logic [ROW_W-1:0] index;
   } match_res_type;

   localparam logic [NAME_MAX_CHARS*8-1:0] NAME_STR [NAME_ROWS] = '{
      "STARTHEXDEC", "STOPHEXDEC", "REPROG", "ADC", "REBOOT", "REBOOTUSB",
      "TEST", "PING", "TIMER", "DEBUGEN", "RGB", "RGBPARAM", "RGBOFF",
      "COMPTEUR", "DECOMPTEUR", "PLUIE", "SUPERPLUIE", "MATCH", "FRD", "FSRD",
      "FWR", "FER", "LOGRST", "LOGINIT", "LOGPRINT", "LOGADD", "LOGFILL",
      "SETUPERASE", "SETUPREAD", "SETUPRELOAD", "SETUPADD", "VERSION",
      "PRINTCMD", "HELP"
   };

   localparam logic [NAME_LEN_W-1:0] NAME_LEN [NAME_ROWS] = '{
      5'd11, 5'd10, 5'd6, 5'd3, 5'd6, 5'd9,
      5'd4, 5'd4, 5'd5, 5'd7, 5'd3, 5'd8, 5'd6,
      5'd8, 5'd10, 5'd5, 5'd10, 5'd5, 5'd3, 5'd4,
      5'd3, 5'd3, 5'd6, 5'd7, 5'd8, 5'd6, 5'd7,
      5'd10, 5'd9, 5'd11, 5'd8, 5'd7,
      5'd8, 5'd4
   };

   function automatic logic [7:0] name_char(input logic [ROW_W-1:0] row,
                                            input logic [NAME_IDX_W-1:0] pos);
      logic [NAME_LEN_W-1:0] len;
      logic [NAME_LEN_W-1:0] ofs;
      logic [7:0]            ch;
      len = NAME_LEN[row];
      ofs = len - {1'b0, pos} - 1'b1;
      ch  = 8'h00;
      if ({1'b0, pos} < len) begin
         ch = NAME_STR[row][{ofs[NAME_IDX_W-1:0], 3'b000} +: 8];
      end
      return ch;
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      logic [7:0] u;
      u = c;
      if (c inside {[8'h61:8'h7A]}) begin
         u = c - CASE_OFFSET;
      end
      return u;
   endfunction

endpackage

### rtl/clkm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data
`timescale 1ns / 1ps
module clkm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/clkm_name_match.sv
// Candidate mask over the command name table and first-match encoder
`timescale 1ns / 1ps
module clkm_name_match
   import clkm_pkg::*;
#(
   parameter int CNT_W = 7
) (
   input  logic              clock,
   input  match_ctl_type     ctl,
   input  logic [CNT_W-1:0]  klen,
   output match_res_type     res
);

   localparam int CMP_W = CNT_W + NAME_LEN_W;

   logic [NAME_ROWS-1:0] cand_ff;
   logic [NAME_ROWS-1:0] cand_in;
   logic [NAME_ROWS-1:0] hit;
   logic [CMP_W-1:0]     klen_x;

   assign klen_x = CMP_W'(klen);

   for (genvar r = 0; r < NAME_ROWS; r++) begin : g_row
      always_comb begin
         cand_in[r] = cand_ff[r];
         if (ctl.clear) begin
            cand_in[r] = 1'b1;
         end else if (ctl.step) begin
            cand_in[r] = cand_ff[r] & ctl.in_name &
                         (name_char(ROW_W'(r), ctl.pos) == ctl.upper);
         end
      end
      assign hit[r] = cand_ff[r] & (klen_x == CMP_W'(NAME_LEN[r]));
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
   end

   always_comb begin
      res.found = 1'b0;
      res.index = '0;
      for (int r = NAME_ROWS - 1; r >= 0; r--) begin
         if (hit[r]) begin
            res.found = 1'b1;
            res.index = ROW_W'(r);
         end
      end
   end

endmodule

### rtl/command_line_keyword_matcher.sv
// Top level of the command line keyword matcher
//
// Bytes arrive one per request on the req_ channel and are kept in a line
// RAM of MAX_LINE bytes. A backspace request drops the last byte; bytes past
// a full line only raise the count to MAX_LINE + 1, which flags overflow.
// A CR or LF request ends the line; an empty line gives no result.
// Ordinary bytes and backspaces are taken whenever the matcher is idle. A line end on a
// non-empty line walks the stored keyword out of the line RAM one byte a
// cycle, bounded by the single read port of the line RAM, narrowing a mask
// of candidate names; an overflowed line skips the walk. The result then
// sits in the rsp_ output register.
// While the receiver stalls the result, new bytes are still taken; a further
// line end finishes its walk and waits until the output register frees.
// Reset empties the line and drops any pending result; the line RAM is not
// cleared, since only bytes below the count are ever read.
`timescale 1ns / 1ps
`include "command_line_keyword_matcher_defines.svh"
module command_line_keyword_matcher
   import clkm_pkg::*;
#(
   parameter int MAX_LINE = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // [1:0] line_status, [7:2] command_index,
                                         // [14:8] keyword_length, [21:15] line_length,
                                         // [28:22] param_start, [31:29] zero
);

   localparam int CNT_W = $clog2(MAX_LINE + 2);
   localparam int AW    = $clog2(MAX_LINE);
   localparam int EXT_W = CNT_W + 8;
   localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_LINE);
   localparam logic [CNT_W-1:0] OVER = CNT_W'(MAX_LINE + 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] llen_ff, llen_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] klen_ff, klen_in;
   status_type       kind_ff, kind_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic             req_fire, is_eol, is_del, rsp_free, scan_last;
   logic             ram_we;
   logic [AW-1:0]    ram_rd_addr;
   logic [7:0]       ram_rd_data;
   logic [CNT_W-1:0] idx_next;
   logic             byte_alnum, byte_colon;
   logic [7:0]       byte_upper;
   logic [EXT_W-1:0] idx_x;
   match_ctl_type    match_ctl;
   match_res_type    match_res;

   logic [CNT_W:0]   klen1, llen_w, pstart_w;
   logic [EXT_W-1:0] klen_x, llen_x, pstart_x;
   status_type       status;
   logic [ROW_W-1:0] index;

   assign req_fire   = req_tvalid & req_tready;
   assign is_eol     = (req_tdata == CHAR_LF) || (req_tdata == CHAR_CR);
   assign is_del     = (req_tdata == CHAR_DEL);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign idx_next   = idx_ff + 1'b1;
   assign scan_last  = (idx_next == llen_ff);
   assign byte_alnum = is_alnum(ram_rd_data);
   assign byte_upper = to_upper(ram_rd_data);
   assign byte_colon = (idx_ff == '0) && (ram_rd_data == CHAR_COLON);
   assign idx_x      = EXT_W'(idx_ff);

   clkm_ram #(
      .WIDTH (8),
      .DEPTH (MAX_LINE)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   clkm_name_match #(
      .CNT_W (CNT_W)
   ) u_name_match (
      .clock (clock),
      .ctl   (match_ctl),
      .klen  (klen_ff),
      .res   (match_res)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && is_eol && count_ff != '0) begin
               state_in = (count_ff == OVER) ? ST_FINISH : ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (byte_colon || !byte_alnum || scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready        = (state_ff == ST_IDLE);
      ram_we            = (state_ff == ST_IDLE) && req_fire && !is_eol && !is_del &&
                          (count_ff < FULL);
      ram_rd_addr       = (state_ff == ST_CHECK) ? idx_next[AW-1:0] : '0;
      match_ctl.clear   = (state_ff == ST_FETCH);
      match_ctl.step    = (state_ff == ST_CHECK) && byte_alnum;
      match_ctl.in_name = (idx_x < EXT_W'(NAME_MAX_CHARS));
      match_ctl.pos     = idx_x[NAME_IDX_W-1:0];
      match_ctl.upper   = byte_upper;
   end

   always_comb begin
      klen1    = {1'b0, klen_ff} + 1'b1;
      llen_w   = {1'b0, llen_ff};
      pstart_w = (klen1 < llen_w) ? klen1 : llen_w;
      klen_x   = EXT_W'(klen_ff);
      llen_x   = EXT_W'(llen_ff);
      pstart_x = EXT_W'(pstart_w);
      status   = kind_ff;
      index    = '0;
      if (kind_ff == STATUS_NOT_FOUND && match_res.found) begin
         status = STATUS_FOUND;
         index  = match_res.index;
      end
      if (kind_ff == STATUS_OVERFLOW || kind_ff == STATUS_HEX) begin
         klen_x   = '0;
         pstart_x = '0;
      end
   end

   always_comb begin
      count_in     = count_ff;
      llen_in      = llen_ff;
      idx_in       = idx_ff;
      klen_in      = klen_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff & !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (is_eol) begin
                  count_in = '0;
                  if (count_ff != '0) begin
                     llen_in = count_ff;
                     idx_in  = '0;
                     klen_in = '0;
                     kind_in = (count_ff == OVER) ? STATUS_OVERFLOW : STATUS_NOT_FOUND;
                  end
               end else if (is_del) begin
                  if (count_ff != '0) begin
                     count_in = count_ff - 1'b1;
                  end
               end else if (count_ff < OVER) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         ST_CHECK: begin
            if (byte_colon) begin
               kind_in = STATUS_HEX;
            end else if (!byte_alnum) begin
               klen_in = idx_ff;
            end else if (scan_last) begin
               klen_in = idx_next;
            end else begin
               idx_in = idx_next;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, pstart_x[6:0], llen_x[6:0], klen_x[6:0],
                               index, status};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      llen_ff     <= llen_in;
      idx_ff      <= idx_in;
      klen_ff     <= klen_in;
      kind_ff     <= kind_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `CLKM_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= OVER)
   `CLKM_ASSERT_IMPLIES(a_scan_index, clock, reset, state_ff == ST_CHECK, idx_ff < llen_ff)
   `CLKM_ASSERT_IMPLIES(a_busy_line, clock, reset, state_ff != ST_IDLE, llen_ff != '0)
   `CLKM_ASSERT_NEXT(a_result_load, clock, reset, state_ff == ST_FINISH && rsp_free,
                     rsp_valid_ff && state_ff == ST_IDLE)

endmodule

### test/line_result_checker.sv
// Checker that predicts and compares the line results of the keyword matcher
`timescale 1ns / 1ps
module line_result_checker
   import clkm_pkg::*;
#(
   parameter int LINE_MAX = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   output int               mismatches,
   output int               outstanding
);

   localparam int COMMAND_COUNT = 34;

   typedef struct packed {
      logic [2:0] pad;
      logic [6:0] param_start;
      logic [6:0] line_length;
      logic [6:0] keyword_length;
      logic [5:0] command_index;
      status_type line_status;
   } line_result_type;

   string commands [0:COMMAND_COUNT-1] = '{
      "STARTHEXDEC", "STOPHEXDEC", "REPROG", "ADC", "REBOOT", "REBOOTUSB",
      "TEST", "PING", "TIMER", "DEBUGEN", "RGB", "RGBPARAM", "RGBOFF",
      "COMPTEUR", "DECOMPTEUR", "PLUIE", "SUPERPLUIE", "MATCH", "FRD", "FSRD",
      "FWR", "FER", "LOGRST", "LOGINIT", "LOGPRINT", "LOGADD", "LOGFILL",
      "SETUPERASE", "SETUPREAD", "SETUPRELOAD", "SETUPADD", "VERSION",
      "PRINTCMD", "HELP"
   };

   logic [7:0]      line_buf [0:LINE_MAX];
   int unsigned     fill = 0;
   line_result_type line_results_q [$];
   int              err_count = 0;

   function automatic logic is_word_char(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic [7:0] upcase(input logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - CASE_OFFSET : c;
   endfunction

   task automatic take_byte(input logic [7:0] c);
      line_result_type r;
      int unsigned     klen;
      int unsigned     llen;
      logic            hit;
      if (c == CHAR_CR || c == CHAR_LF) begin
         llen = fill;
         fill = 0;
         if (llen != 0) begin
            r = '0;
            r.line_length = 7'(llen);
            if (llen == LINE_MAX + 1) begin
               r.line_status = STATUS_OVERFLOW;
            end else if (line_buf[0] == CHAR_COLON) begin
               r.line_status = STATUS_HEX;
            end else begin
               klen = 0;
               while (klen < llen && is_word_char(line_buf[klen])) klen++;
               r.keyword_length = 7'(klen);
               r.param_start    = 7'((klen + 1 < llen) ? klen + 1 : llen);
               r.line_status    = STATUS_NOT_FOUND;
               for (int row = 0; row < COMMAND_COUNT; row++) begin
                  if (r.line_status != STATUS_FOUND && klen > 0 &&
                      commands[row].len() == klen) begin
                     hit = 1'b1;
                     for (int i = 0; i < klen; i++) begin
                        if (commands[row][i] != upcase(line_buf[i])) hit = 1'b0;
                     end
                     if (hit) begin
                        r.line_status   = STATUS_FOUND;
                        r.command_index = 6'(row);
                     end
                  end
               end
            end
            line_results_q.push_back(r);
         end
      end else if (c == CHAR_DEL) begin
         if (fill > 0) fill--;
      end else if (fill < LINE_MAX) begin
         line_buf[fill] = c;
         fill++;
      end else if (fill == LINE_MAX) begin
         fill++;
      end
   endtask

   task automatic note(input string field, input int want, input int got);
      if (err_count < 10) begin
         $display("mismatch in %s: expected %0d, got %0d", field, want, got);
      end
      err_count++;
   endtask

   always @(posedge clock) begin
      line_result_type want;
      line_result_type got;
      if (reset) begin
         fill = 0;
         line_results_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (line_results_q.size() == 0) begin
               if (err_count < 10) begin
                  $display("result %h arrived with no line pending", rsp_tdata);
               end
               err_count++;
            end else begin
               want = line_results_q.pop_front();
               if (got.line_status !== want.line_status) begin
                  note("line_status", int'(want.line_status), int'(got.line_status));
               end
               if (got.command_index !== want.command_index) begin
                  note("command_index", want.command_index, got.command_index);
               end
               if (got.keyword_length !== want.keyword_length) begin
                  note("keyword_length", want.keyword_length, got.keyword_length);
               end
               if (got.line_length !== want.line_length) begin
                  note("line_length", want.line_length, got.line_length);
               end
               if (got.param_start !== want.param_start) begin
                  note("param_start", want.param_start, got.param_start);
               end
               if (got.pad !== want.pad) begin
                  note("padding", want.pad, got.pad);
               end
            end
         end
         if (req_tvalid && req_tready) take_byte(req_tdata);
      end
      mismatches  <= err_count;
      outstanding <= line_results_q.size();
   end

endmodule

### test/tb.sv
// Testbench top for the command line keyword matcher: stimulus, stalls and verdict
`timescale 1ns / 1ps
module tb;
   import clkm_pkg::*;

   localparam int LINE_MAX      = 64;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 100;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic [7:0]       req_tdata  = '0;
   logic             rsp_tready = 1'b0;
   logic             req_tready;
   logic             rsp_tvalid;
   logic [RSP_W-1:0] rsp_tdata;
   int               mismatches;
   int               outstanding;

   logic       calm_tx    = 1'b0;
   logic       calm_rx    = 1'b0;
   int         stall_left = 0;
   int         cycles     = 0;
   int         bytes_sent = 0;
   int         lines_made = 0;
   logic [7:0] line_q [$];

   always #5 clock = ~clock;

   command_line_keyword_matcher #(
      .MAX_LINE(LINE_MAX)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   line_result_checker #(
      .LINE_MAX(LINE_MAX)
   ) u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // hold ready low for a drawn number of cycles after each result, and now and then at random, unless calm_rx is set
   always @(posedge clock) begin
      int w;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         w = calm_rx ? 0 : $urandom_range(0, 17);
         stall_left <= w;
         rsp_tready <= (w == 0);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if (!calm_rx && $urandom_range(0, 19) == 0) begin
         stall_left <= $urandom_range(1, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic push_byte(input logic [7:0] b);
      int gap;
      gap = calm_tx ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic flush_line();
      foreach (line_q[i]) push_byte(line_q[i]);
      line_q.delete();
      lines_made++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
   endtask

   task automatic add_fill(input logic [7:0] c, input int n);
      repeat (n) line_q.push_back(c);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [7:0] rand_word_char();
      logic [7:0] c;
      case ($urandom_range(0, 2))
         0: c = 8'("0" + $urandom_range(0, 9));
         1: c = 8'("A" + $urandom_range(0, 25));
         default: c = 8'("a" + $urandom_range(0, 25));
      endcase
      return c;
   endfunction

   task automatic add_params();
      repeat ($urandom_range(0, 10)) line_q.push_back(8'($urandom_range(32, 126)));
   endtask

   task automatic make_random_line();
      int         kind;
      int         row;
      int         len;
      logic [7:0] c;
      string      hex_digits;
      hex_digits = "0123456789ABCDEF";
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
         row = $urandom_range(0, NAME_ROWS - 1);
         len = NAME_LEN[row];
         for (int i = 0; i < len; i++) begin
            c = NAME_STR[row][8*(len-1-i) +: 8];
            if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) c = c + CASE_OFFSET;
            line_q.push_back(c);
         end
         case ($urandom_range(0, 5))
            0: ;
            1: begin
               line_q.push_back(" ");
               add_params();
            end
            2: begin
               line_q.push_back(rand_word_char());
               add_params();
            end
            3: void'(line_q.pop_back());
            4: begin
               line_q.push_back(rand_word_char());
               line_q.push_back(CHAR_DEL);
            end
            default: begin
               line_q.push_back(8'($urandom_range(32, 47)));
               add_params();
            end
         endcase
      end else if (kind < 65) begin
         line_q.push_back(CHAR_COLON);
         repeat ($urandom_range(0, 20)) line_q.push_back(hex_digits[$urandom_range(0, 15)]);
      end else if (kind < 78) begin
         repeat ($urandom_range(1, 20)) line_q.push_back(rand_word_char());
         if ($urandom_range(0, 1) == 1) begin
            line_q.push_back(" ");
            add_params();
         end
      end else if (kind < 90) begin
         repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 95) begin
         repeat ($urandom_range(60, 72)) begin
            if ($urandom_range(0, 14) == 0) line_q.push_back(CHAR_DEL);
            else line_q.push_back(8'($urandom_range(32, 126)));
         end
      end else begin
         add_fill(CHAR_DEL, $urandom_range(0, 3));
      end
      case ($urandom_range(0, 2))
         0: line_q.push_back(CHAR_CR);
         1: line_q.push_back(CHAR_LF);
         default: begin
            line_q.push_back(CHAR_CR);
            line_q.push_back(CHAR_LF);
         end
      endcase
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      line_q = '{CHAR_CR, CHAR_LF, CHAR_DEL, CHAR_LF};
      flush_line();
      add_text("help");
      line_q.push_back(CHAR_LF);
      add_text("Adc x");
      line_q.push_back(CHAR_CR);
      line_q.push_back(CHAR_COLON);
      line_q.push_back(CHAR_LF);
      line_q.push_back(8'h00);
      line_q.push_back(8'hFF);
      line_q.push_back(" ");
      line_q.push_back(CHAR_CR);
      add_text("pingQ");
      line_q.push_back(CHAR_DEL);
      line_q.push_back(CHAR_LF);
      add_text("STARTHEXDECX");
      line_q.push_back(CHAR_LF);
      add_text("z");
      line_q.push_back(CHAR_CR);
      flush_line();
      // drop back from overflow with a delete, then overflow for real
      add_fill("W", LINE_MAX + 2);
      line_q.push_back(CHAR_DEL);
      line_q.push_back(CHAR_LF);
      add_fill("9", LINE_MAX + 6);
      line_q.push_back(CHAR_CR);
      add_text("PRINTCMD");
      line_q.push_back(CHAR_CR);
      add_text("version 1");
      line_q.push_back(CHAR_LF);
      flush_line();
      wait_drained();

      lines_made = 0;
      while (bytes_sent < 500) begin
         calm_tx = ($urandom_range(0, 3) == 0);
         calm_rx = ($urandom_range(0, 3) == 0);
         make_random_line();
         flush_line();
         if (lines_made % 25 == 0 && $urandom_range(0, 1) == 1) wait_drained();
      end

      calm_tx = 1'b0;
      calm_rx = 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
